// ===== sv/tlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants of the thick line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int DefFrameWidth   = 1024;
  localparam int DefFrameHeight  = 1024;
  localparam int DefMaxThickness = 7;

  localparam int CoordW = 12;
  localparam int PointW = 13;
  localparam int ErrW   = 14;
  localparam int ThickW = 3;
  localparam int OffW   = 4;
  localparam int ColorW = 32;
  localparam int PixW   = 10;
  localparam int IndexW = 20;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // classified item handed from the front to the stepper
  typedef struct packed {
    action_t                   act;
    logic signed [CoordW-1:0]  x0;
    logic signed [CoordW-1:0]  y0;
    logic signed [CoordW-1:0]  x1;
    logic signed [CoordW-1:0]  y1;
    logic [CoordW-1:0]         dx;
    logic [CoordW-1:0]         dy;
    logic                      dir_x_neg;
    logic                      dir_y_neg;
    logic [ThickW-1:0]         thick;
    logic [ColorW-1:0]         color;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   py;
    logic [IndexW-1:0] idx;
    logic [ColorW-1:0] rgba;
    logic              last;
  } result_t;

endpackage

// ===== sv/tlr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_front
// Input side: decodes each item, precomputes line deltas and directions,
// clamps the thickness and holds items in a two-entry queue for the stepper.
// ----------------------------------------------------------------------------
module tlr_front import tlr_pkg::*; #(
  parameter int MAX_THICKNESS = DefMaxThickness
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     action,
  input  logic signed [CoordW-1:0] start_x,
  input  logic signed [CoordW-1:0] start_y,
  input  logic signed [CoordW-1:0] end_x,
  input  logic signed [CoordW-1:0] end_y,
  input  logic [ThickW-1:0]        half_width,
  input  logic [ColorW-1:0]        rgba,
  output logic                     item_valid,
  input  logic                     item_ready,
  output item_t                    item
);

  localparam logic [ThickW:0] MaxThick = (ThickW + 1)'(MAX_THICKNESS);

  item_t        slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  item_t        decoded;
  logic [CoordW:0] diff_x, diff_y, ndiff_x, ndiff_y;
  logic         wr_en, rd_en;

  always_comb begin
    diff_x  = {end_x[CoordW-1], end_x} - {start_x[CoordW-1], start_x};
    diff_y  = {end_y[CoordW-1], end_y} - {start_y[CoordW-1], start_y};
    ndiff_x = {start_x[CoordW-1], start_x} - {end_x[CoordW-1], end_x};
    ndiff_y = {start_y[CoordW-1], start_y} - {end_y[CoordW-1], end_y};

    decoded.act       = action_t'(action);
    decoded.x0        = start_x;
    decoded.y0        = start_y;
    decoded.x1        = end_x;
    decoded.y1        = end_y;
    decoded.dir_x_neg = !(start_x < end_x);
    decoded.dir_y_neg = !(start_y < end_y);
    decoded.dx        = decoded.dir_x_neg ? ndiff_x[CoordW-1:0] : diff_x[CoordW-1:0];
    decoded.dy        = decoded.dir_y_neg ? ndiff_y[CoordW-1:0] : diff_y[CoordW-1:0];
    decoded.thick     = ({1'b0, half_width} > MaxThick) ? MaxThick[ThickW-1:0] : half_width;
    decoded.color     = rgba;
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== sv/tlr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_back
// Stepper: holds the Bresenham state, walks the brush square around each
// point and emits one pixel transfer per step item while a line is active.
// ----------------------------------------------------------------------------
module tlr_back import tlr_pkg::*; #(
  parameter int FRAME_WIDTH  = DefFrameWidth,
  parameter int FRAME_HEIGHT = DefFrameHeight
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam logic [14:0] FrameW15 = 15'(FRAME_WIDTH);
  localparam logic [14:0] FrameH15 = 15'(FRAME_HEIGHT);
  localparam logic [11:0] FrameW12 = 12'(FRAME_WIDTH);

  logic               busy;
  logic [PointW-1:0]  point_x, point_y;
  logic [CoordW-1:0]  target_x, target_y;
  logic [CoordW-1:0]  delta_x, delta_y;
  logic               dir_x_neg, dir_y_neg;
  logic [ErrW-1:0]    error_term;
  logic [OffW-1:0]    offset_x, offset_y;
  logic [ThickW-1:0]  thickness_reg;
  logic [ColorW-1:0]  color_reg;

  logic               fire, step;
  logic [14:0]        pos_x, pos_y;
  logic               in_frame;
  logic [22:0]        row_base;
  logic [22:0]        lin_idx;
  logic [OffW-1:0]    side;
  logic               end_y_col, end_square, at_target;
  logic signed [14:0] e2, dx_s, dy_s;
  logic               move_x, move_y;
  logic [ErrW-1:0]    err_step;

  always_comb begin
    pos_x    = {{2{point_x[PointW-1]}}, point_x} - 15'(thickness_reg) + 15'(offset_x);
    pos_y    = {{2{point_y[PointW-1]}}, point_y} - 15'(thickness_reg) + 15'(offset_y);
    in_frame = !pos_x[14] && !pos_y[14] && (pos_x < FrameW15) && (pos_y < FrameH15);
    row_base = 23'(pos_y[10:0]) * 23'(FrameW12);
    lin_idx  = row_base + 23'(pos_x[10:0]);

    side       = {thickness_reg, 1'b0};
    end_y_col  = !(offset_y < side);
    end_square = end_y_col && !(offset_x < side);
    at_target  = (point_x == {target_x[CoordW-1], target_x})
              && (point_y == {target_y[CoordW-1], target_y});

    e2       = $signed({error_term, 1'b0});
    dx_s     = $signed({3'b000, delta_x});
    dy_s     = $signed({3'b000, delta_y});
    move_x   = e2 > -dy_s;
    move_y   = e2 < dx_s;
    err_step = error_term - (move_x ? {2'b00, delta_y} : '0)
                          + (move_y ? {2'b00, delta_x} : '0);
  end

  assign item_ready = !res_full;
  assign fire       = item_valid && item_ready;
  assign step       = fire && (item.act == ACT_STEP) && busy;
  assign res_push   = step;

  always_comb begin
    res.we   = in_frame;
    res.px   = in_frame ? pos_x[PixW-1:0] : '0;
    res.py   = in_frame ? pos_y[PixW-1:0] : '0;
    res.idx  = in_frame ? lin_idx[IndexW-1:0] : '0;
    res.rgba = color_reg;
    res.last = end_square && at_target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      point_x       <= '0;
      point_y       <= '0;
      target_x      <= '0;
      target_y      <= '0;
      delta_x       <= '0;
      delta_y       <= '0;
      dir_x_neg     <= 1'b0;
      dir_y_neg     <= 1'b0;
      error_term    <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
      thickness_reg <= '0;
      color_reg     <= '0;
    end else if (fire && (item.act == ACT_START)) begin
      busy          <= 1'b1;
      point_x       <= {item.x0[CoordW-1], item.x0};
      point_y       <= {item.y0[CoordW-1], item.y0};
      target_x      <= item.x1;
      target_y      <= item.y1;
      delta_x       <= item.dx;
      delta_y       <= item.dy;
      dir_x_neg     <= item.dir_x_neg;
      dir_y_neg     <= item.dir_y_neg;
      error_term    <= {2'b00, item.dx} - {2'b00, item.dy};
      offset_x      <= '0;
      offset_y      <= '0;
      thickness_reg <= item.thick;
      color_reg     <= item.color;
    end else if (step) begin
      if (!end_y_col) begin
        offset_y <= offset_y + 1'b1;
      end else begin
        offset_y <= '0;
        if (!end_square) begin
          offset_x <= offset_x + 1'b1;
        end else begin
          offset_x <= '0;
          if (at_target) begin
            busy <= 1'b0;
          end else begin
            error_term <= err_step;
            if (move_x) begin
              point_x <= point_x + (dir_x_neg ? {PointW{1'b1}} : PointW'(1));
            end
            if (move_y) begin
              point_y <= point_y + (dir_y_neg ? {PointW{1'b1}} : PointW'(1));
            end
          end
        end
      end
    end
  end

endmodule

// ===== sv/tlr_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_out_queue
// Two-entry result queue between the stepper and the pixel write port.
// ----------------------------------------------------------------------------
module tlr_out_queue import tlr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_push,
  input  result_t wr_data,
  output logic    wr_full,
  input  logic    pop,
  output logic    empty,
  output result_t rd_data
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en, rd_en;

  assign wr_full = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = slots[rd_ptr];
  assign wr_en   = wr_push && !wr_full;
  assign rd_en   = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== sv/thick_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Bresenham line rasterizer with a square brush of side 2t+1.
// ----------------------------------------------------------------------------
// Usage: push a start item (action 0) to load a line, then push one step
// item (action 1) per pixel wanted; each step while a line is active gives
// one pixel transfer, the brush square walked x-outer, y-inner, and the
// final position of the endpoint square carries last. Steps while idle give
// nothing. The block takes one item per cycle sustained while the result
// queue has room: the stepper does one brush position per cycle with a
// single add, compare and multiply for the linear index. A result is pushed
// into the result queue in the cycle its step item is taken by the stepper
// (input queue, then stepper into the two-entry result queue); both queues
// let either side stall without stopping the other until the queue is full.
// ----------------------------------------------------------------------------
module thick_line_rasterizer import tlr_pkg::*; #(
  parameter int FRAME_WIDTH   = DefFrameWidth,
  parameter int FRAME_HEIGHT  = DefFrameHeight,
  parameter int MAX_THICKNESS = DefMaxThickness
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     action,
  input  logic signed [CoordW-1:0] start_x,
  input  logic signed [CoordW-1:0] start_y,
  input  logic signed [CoordW-1:0] end_x,
  input  logic signed [CoordW-1:0] end_y,
  input  logic [ThickW-1:0]        half_width,
  input  logic [ColorW-1:0]        rgba,
  output logic                     empty,
  input  logic                     pop,
  output logic                     write_enable,
  output logic [PixW-1:0]          pixel_x,
  output logic [PixW-1:0]          pixel_y,
  output logic [IndexW-1:0]        pixel_index,
  output logic [ColorW-1:0]        pixel_rgba,
  output logic                     last
);

  logic    item_valid, item_ready;
  item_t   item;
  logic    res_push, res_full;
  result_t res, head;

  tlr_front #(
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .half_width (half_width),
    .rgba       (rgba),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  tlr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  tlr_out_queue u_out (
    .clk     (clk),
    .rst     (rst),
    .wr_push (res_push),
    .wr_data (res),
    .wr_full (res_full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (head)
  );

  assign write_enable = head.we;
  assign pixel_x      = head.px;
  assign pixel_y      = head.py;
  assign pixel_index  = head.idx;
  assign pixel_rgba   = head.rgba;
  assign last         = head.last;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_reset_clears: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_off_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !write_enable) |-> (pixel_x == '0 && pixel_y == '0 && pixel_index == '0))
    else $error("off-frame result carries coordinates");

endmodule
